>>> rtl/rgb_contrast_stretch_top_macros.svh
// Assertion macros for the contrast stretch block.
// Used by rgb_contrast_stretch_top; no other dependencies.
`ifndef RGB_CONTRAST_STRETCH_TOP_MACROS_SVH
`define RGB_CONTRAST_STRETCH_TOP_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define RCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// antecedent holds -> consequent holds in the next cycle
`define RCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define RCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/rcs_pkg.sv
// Shared types and constants for the RGB contrast stretch block.
// No dependencies.
`default_nettype none
package rcs_pkg;

  localparam int PIX_W           = 8;
  localparam int MASK_W          = 3;
  localparam int NUM_CH          = 3;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

  // Item classes decided at the front
  typedef enum logic [1:0] {
    KIND_GATHER  = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_STRETCH = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } item_t;

endpackage
`default_nettype wire

>>> rtl/rgb_contrast_stretch_top.sv
// RGB min/max contrast stretch: a queueing front end feeding an executing
// back end. Depends on rcs_pkg, rcs_front, rcs_back and the macros header.
`default_nettype none
`include "rgb_contrast_stretch_top_macros.svh"
// Gather pixels (opcode 0) update each channel's low/high, first_pixel loads
// them; they give no result. Stretch pixels (opcode 1) give one result each:
// per channel the low byte of (x - low) * floor(255 / (high - low)), or 0
// with its flat_mask bit set when the channel has no range. The front end
// takes one pixel per cycle while its QUEUE_DEPTH-entry queue is not full;
// the back end retires one gather or one stretch per cycle unless it is
// dividing or a stretch finds the result register held. The first stretch
// after reset or after any gather waits while the bit-serial divider starts
// and rebuilds the scales (one quotient bit per cycle, three channels in
// parallel). out_valid follows the queue slot and the result register.
module rgb_contrast_stretch_top #(
  parameter int QUEUE_DEPTH = rcs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       opcode,
  input  wire logic                       first_pixel,
  input  wire logic [rcs_pkg::PIX_W-1:0]  red_in,
  input  wire logic [rcs_pkg::PIX_W-1:0]  green_in,
  input  wire logic [rcs_pkg::PIX_W-1:0]  blue_in,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rcs_pkg::PIX_W-1:0]       red_out,
  output logic [rcs_pkg::PIX_W-1:0]       green_out,
  output logic [rcs_pkg::PIX_W-1:0]       blue_out,
  output logic [rcs_pkg::MASK_W-1:0]      flat_mask
);
  import rcs_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  rcs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .first_pixel(first_pixel),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  rcs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red_out  (red_out),
    .green_out(green_out),
    .blue_out (blue_out),
    .flat_mask(flat_mask)
  );

  // Checks
  `RCS_ASSERT_NEXT(a_push_visible, clk, rst, in_valid && in_ready, q_valid,
                   "transfer in not queued")
  `RCS_ASSERT_NEXT(a_stretch_emits, clk, rst,
                   q_valid && q_ready && q_item.kind == KIND_STRETCH, out_valid,
                   "stretch retired without result")
  `RCS_ASSERT_SAME(a_flat_red_zero, clk, rst, out_valid && flat_mask[0], red_out == '0,
                   "flat red channel not zero")

endmodule
`default_nettype wire

>>> rtl/rcs_front.sv
// Front end: accepts pixels, classifies them, and queues them for the back end.
// Depends on rcs_pkg.
`default_nettype none
module rcs_front #(
  parameter int QUEUE_DEPTH = rcs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      opcode,
  input  wire logic                      first_pixel,
  input  wire logic [rcs_pkg::PIX_W-1:0] red_in,
  input  wire logic [rcs_pkg::PIX_W-1:0] green_in,
  input  wire logic [rcs_pkg::PIX_W-1:0] blue_in,
  output logic                           q_valid,
  input  wire logic                      q_ready,
  output rcs_pkg::item_t                 q_item
);
  import rcs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  item_t            cls_item;
  logic             push;
  logic             pop;

  // Classify the incoming pixel
  always_comb begin
    cls_item.red   = red_in;
    cls_item.green = green_in;
    cls_item.blue  = blue_in;
    if (opcode) begin
      cls_item.kind = KIND_STRETCH;
    end else if (first_pixel) begin
      cls_item.kind = KIND_LOAD;
    end else begin
      cls_item.kind = KIND_GATHER;
    end
  end

  assign in_ready = (count != FULL_CNT);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls_item;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/rcs_back.sv
// Back end: tracks channel extremes, derives scales with per-channel bit-serial
// dividers, and stretches pixels into a registered result. Depends on rcs_pkg.
`default_nettype none
module rcs_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire rcs_pkg::item_t              q_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [rcs_pkg::PIX_W-1:0]        red_out,
  output logic [rcs_pkg::PIX_W-1:0]        green_out,
  output logic [rcs_pkg::PIX_W-1:0]        blue_out,
  output logic [rcs_pkg::MASK_W-1:0]       flat_mask
);
  import rcs_pkg::*;

  localparam int STEP_W = $clog2(PIX_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PIX_W - 1);

  typedef enum logic {ST_RUN, ST_DIVIDE} state_t;

  state_t                              state;
  logic                                scale_ok;
  logic [STEP_W-1:0]                   step;
  logic [NUM_CH-1:0][PIX_W-1:0]        low;
  logic [NUM_CH-1:0][PIX_W-1:0]        high;
  logic [NUM_CH-1:0][PIX_W-1:0]        scale;
  logic [NUM_CH-1:0][PIX_W-1:0]        rem;

  logic [NUM_CH-1:0][PIX_W-1:0]        pix;
  logic [NUM_CH-1:0][PIX_W-1:0]        rng;
  logic [NUM_CH-1:0]                   flat;
  logic [NUM_CH-1:0][PIX_W-1:0]        rem_next;
  logic [NUM_CH-1:0]                   qbit;
  logic [NUM_CH-1:0][PIX_W-1:0]        stretched;
  logic [NUM_CH-1:0][PIX_W-1:0]        low_next;
  logic [NUM_CH-1:0][PIX_W-1:0]        high_next;
  logic                                pop;
  logic                                start_div;

  assign pix = {q_item.blue, q_item.green, q_item.red};

  // Per-channel range, flat test, divider step, stretch and extreme update
  always_comb begin
    logic [PIX_W:0]     shifted;
    logic [PIX_W:0]     diff9;
    logic [PIX_W-1:0]   diff;
    logic [2*PIX_W-1:0] prod;
    for (int c = 0; c < NUM_CH; c++) begin
      flat[c]  = !(high[c] > low[c]);
      rng[c]   = high[c] - low[c];
      // restoring step of FULL_SCALE / range, one quotient bit a cycle
      shifted  = {rem[c], FULL_SCALE[step]};
      diff9    = shifted - {1'b0, rng[c]};
      qbit[c]  = !diff9[PIX_W];
      rem_next[c] = qbit[c] ? diff9[PIX_W-1:0] : shifted[PIX_W-1:0];
      // stretch: low byte of (x - low) * scale
      diff     = pix[c] - low[c];
      prod     = (2*PIX_W)'(diff) * (2*PIX_W)'(scale[c]);
      stretched[c] = flat[c] ? '0 : prod[PIX_W-1:0];
      // extremes
      low_next[c]  = low[c];
      high_next[c] = high[c];
      if (q_item.kind == KIND_LOAD) begin
        low_next[c]  = pix[c];
        high_next[c] = pix[c];
      end else begin
        if (pix[c] < low[c]) begin
          low_next[c] = pix[c];
        end
        if (pix[c] > high[c]) begin
          high_next[c] = pix[c];
        end
      end
    end
  end

  // Which queued item can retire this cycle
  always_comb begin
    q_ready = 1'b0;
    if (state == ST_RUN) begin
      case (q_item.kind)
        KIND_GATHER,
        KIND_LOAD:    q_ready = 1'b1;
        KIND_STRETCH: q_ready = scale_ok && (!out_valid || out_ready);
        default:      q_ready = 1'b1;
      endcase
    end
  end

  assign pop       = q_valid && q_ready;
  assign start_div = (state == ST_RUN) && q_valid &&
                     (q_item.kind == KIND_STRETCH) && !scale_ok;

  // Control, extremes, divider and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      scale_ok  <= 1'b0;
      out_valid <= 1'b0;
      low       <= '0;
      high      <= '0;
    end else begin
      // result valid: set by a retired stretch, cleared by a transfer out
      if (pop && (q_item.kind == KIND_STRETCH)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RUN: begin
          if (start_div) begin
            state <= ST_DIVIDE;
            step  <= LAST_STEP;
            rem   <= '0;
            scale <= '0;
          end else if (pop) begin
            case (q_item.kind)
              KIND_GATHER,
              KIND_LOAD: begin
                low      <= low_next;
                high     <= high_next;
                scale_ok <= 1'b0;
              end
              KIND_STRETCH: begin
                red_out   <= stretched[0];
                green_out <= stretched[1];
                blue_out  <= stretched[2];
                flat_mask <= flat;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIVIDE: begin
          for (int c = 0; c < NUM_CH; c++) begin
            rem[c]   <= rem_next[c];
            scale[c] <= {scale[c][PIX_W-2:0], qbit[c]};
          end
          step <= step - 1'b1;
          if (step == '0) begin
            state    <= ST_RUN;
            scale_ok <= 1'b1;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/rgb_contrast_stretch_top_tb.sv
// Self-checking testbench for rgb_contrast_stretch_top: gather and stretch pixel streams
// against a built-in predictor of the per-channel extremes and stretched outputs.
// Depends on rcs_pkg and the rgb_contrast_stretch_top RTL.
module rgb_contrast_stretch_top_tb;
  import rcs_pkg::*;

  localparam logic OP_GATHER    = 1'b0;
  localparam logic OP_STRETCH   = 1'b1;
  localparam int   PIXEL_TARGET = 1950;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   CYCLE_LIMIT  = 1000000;
  localparam int   REPORT_MAX   = 10;

  typedef struct {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [MASK_W-1:0] mask;
  } stretch_result_t;

  logic              clk;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic              opcode      = OP_GATHER;
  logic              first_pixel = 1'b0;
  logic [PIX_W-1:0]  red_in      = '0;
  logic [PIX_W-1:0]  green_in    = '0;
  logic [PIX_W-1:0]  blue_in     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [PIX_W-1:0]  red_out;
  logic [PIX_W-1:0]  green_out;
  logic [PIX_W-1:0]  blue_out;
  logic [MASK_W-1:0] flat_mask;

  // predictor state: per-channel extremes, index 0 red, 1 green, 2 blue
  logic [PIX_W-1:0]  chan_low  [NUM_CH];
  logic [PIX_W-1:0]  chan_high [NUM_CH];
  stretch_result_t   stretched_q[$];

  int  mismatches  = 0;
  int  pixels_sent = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  bit  no_idle     = 1'b0;

  rgb_contrast_stretch_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .first_pixel (first_pixel),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .flat_mask   (flat_mask)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               stretched_q.size());
      $display("FAIL rgb_contrast_stretch_top");
      $finish;
    end
  end

  // stretch of one channel: low byte of (x - low) * floor(255 / range), flat if no range
  function automatic logic [PIX_W-1:0] stretch_sample(input logic [PIX_W-1:0] x,
                                                      input logic [PIX_W-1:0] lo,
                                                      input logic [PIX_W-1:0] hi,
                                                      output logic flat);
    int unsigned scale;
    int unsigned diff;
    if (hi <= lo) begin
      flat = 1'b1;
      return '0;
    end
    flat  = 1'b0;
    scale = int'(FULL_SCALE) / (int'(hi) - int'(lo));
    diff  = (int'(x) - int'(lo)) & 8'hFF;
    return PIX_W'((diff * scale) & 8'hFF);
  endfunction

  // update extremes on a gather, queue the expected result on a stretch
  task automatic apply_pixel(input logic op, input logic first,
                             input logic [PIX_W-1:0] r, g, b);
    logic [PIX_W-1:0] px [NUM_CH];
    logic             flat [NUM_CH];
    logic [PIX_W-1:0] res [NUM_CH];
    stretch_result_t  want;
    px[0] = r;
    px[1] = g;
    px[2] = b;
    if (op == OP_GATHER) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (first) begin
          chan_low[c]  = px[c];
          chan_high[c] = px[c];
        end else begin
          if (px[c] < chan_low[c])  chan_low[c]  = px[c];
          if (px[c] > chan_high[c]) chan_high[c] = px[c];
        end
      end
    end else begin
      for (int c = 0; c < NUM_CH; c++)
        res[c] = stretch_sample(px[c], chan_low[c], chan_high[c], flat[c]);
      want.red   = res[0];
      want.green = res[1];
      want.blue  = res[2];
      want.mask  = {flat[2], flat[1], flat[0]};
      stretched_q.push_back(want);
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // one input transfer; valid stays high across back-to-back items
  task automatic send_pixel(input logic op, input logic first,
                            input logic [PIX_W-1:0] r, g, b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    first_pixel <= first;
    red_in      <= r;
    green_in    <= g;
    blue_in     <= b;
    do @(posedge clk); while (!in_ready);
    apply_pixel(op, first, r, g, b);
    pixels_sent++;
  endtask

  // hold off the sender until every expected result has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (stretched_q.size() != 0);
  endtask

  // result check and output stall pattern
  always @(posedge clk) begin : result_check
    stretch_result_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (stretched_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result r=%0d g=%0d b=%0d mask=%0d", red_out, green_out,
                     blue_out, flat_mask);
        end else begin
          want = stretched_q.pop_front();
          if (red_out !== want.red || green_out !== want.green ||
              blue_out !== want.blue || flat_mask !== want.mask) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch: expected r=%0d g=%0d b=%0d mask=%0d, got r=%0d g=%0d b=%0d mask=%0d",
                       want.red, want.green, want.blue, want.mask,
                       red_out, green_out, blue_out, flat_mask);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) >= 70) begin
        stall_left = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 29);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stretch before any gather: every channel flat
  task automatic test_reset_extremes();
    send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_STRETCH, 1'b1, 8'd255, 8'd255, 8'd255);
  endtask

  // gather without the first mark keeps low at its reset value of zero
  task automatic test_gather_without_first();
    send_pixel(OP_GATHER, 1'b0, 8'd10, 8'd200, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd100, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd255, 8'd128, 8'd1);
  endtask

  // full 0..255 range, scale of one
  task automatic test_full_range();
    send_pixel(OP_GATHER, 1'b1, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_GATHER, 1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd128, 8'd255);
    send_pixel(OP_STRETCH, 1'b1, 8'd255, 8'd1, 8'd127);
  endtask

  // samples under the gathered low wrap before the multiply
  task automatic test_below_low();
    send_pixel(OP_GATHER, 1'b1, 8'd100, 8'd50, 8'd200);
    send_pixel(OP_GATHER, 1'b0, 8'd110, 8'd250, 8'd201);
    send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_STRETCH, 1'b0, 8'd109, 8'd49, 8'd255);
  endtask

  // flat channels give zero and set their mask bit, one channel at a time opens up
  task automatic test_flat_channels();
    send_pixel(OP_GATHER, 1'b1, 8'd7, 8'd0, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd7, 8'd0, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd8, 8'd1, 8'd254);
    send_pixel(OP_GATHER, 1'b0, 8'd8, 8'd0, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd8, 8'd0, 8'd255);
    send_pixel(OP_GATHER, 1'b0, 8'd8, 8'd1, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd7, 8'd1, 8'd255);
    send_pixel(OP_STRETCH, 1'b1, 8'd170, 8'd85, 8'd0);
  endtask

  // random frames: mostly a marked gather pass then a stretch pass, some broken, some noise
  task automatic test_random_frames();
    logic [PIX_W-1:0] span_lo [NUM_CH];
    logic [PIX_W-1:0] span_hi [NUM_CH];
    logic [PIX_W-1:0] px [NUM_CH];
    int width;
    int kind;
    int n_gather;
    int n_stretch;
    int frame = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      frame++;
      no_idle = ($urandom_range(0, 9) == 0);
      for (int c = 0; c < NUM_CH; c++) begin
        case ($urandom_range(0, 5))
          0:       width = 0;
          1:       width = $urandom_range(1, 2);
          2:       width = $urandom_range(3, 15);
          3:       width = $urandom_range(16, 127);
          4:       width = $urandom_range(128, 254);
          default: width = 255;
        endcase
        span_lo[c] = PIX_W'($urandom_range(255 - width, 0));
        span_hi[c] = PIX_W'(int'(span_lo[c]) + width);
      end
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        n_gather  = $urandom_range(1, 8);
        n_stretch = $urandom_range(1, 12);
        for (int i = 0; i < n_gather; i++) begin
          for (int c = 0; c < NUM_CH; c++)
            px[c] = PIX_W'($urandom_range(span_hi[c], span_lo[c]));
          send_pixel(OP_GATHER, i == 0, px[0], px[1], px[2]);
        end
        for (int i = 0; i < n_stretch; i++) begin
          for (int c = 0; c < NUM_CH; c++)
            px[c] = ($urandom_range(0, 99) < 85) ?
                    PIX_W'($urandom_range(span_hi[c], span_lo[c])) : PIX_W'($urandom);
          send_pixel(OP_STRETCH, 1'($urandom_range(0, 1)), px[0], px[1], px[2]);
        end
      end else if (kind == 8) begin
        // interleaved gathers and stretches, first mark rare
        n_gather = $urandom_range(2, 10);
        for (int i = 0; i < n_gather; i++) begin
          for (int c = 0; c < NUM_CH; c++)
            px[c] = PIX_W'($urandom_range(span_hi[c], span_lo[c]));
          send_pixel(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                     px[0], px[1], px[2]);
        end
      end else begin
        n_gather = $urandom_range(1, 6);
        for (int i = 0; i < n_gather; i++)
          send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), PIX_W'($urandom),
                     PIX_W'($urandom), PIX_W'($urandom));
      end
      if (frame % 25 == 0) wait_results_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      chan_low[c]  = '0;
      chan_high[c] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_extremes();
    test_gather_without_first();
    test_full_range();
    wait_results_drained();
    test_below_low();
    test_flat_channels();
    test_random_frames();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && stretched_q.size() == 0) begin
      $display("PASS rgb_contrast_stretch_top");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, stretched_q.size());
      $display("FAIL rgb_contrast_stretch_top");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rcs_pkg.sv
rtl/rcs_front.sv
rtl/rcs_back.sv
rtl/rgb_contrast_stretch_top.sv
tb/sv/rgb_contrast_stretch_top_tb.sv
